// ----- hdl/kvl_pkg.sv -----
package kvl_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned ROW_W       = 4 * DATA_W;   // {z, y, x, time}
   localparam int unsigned KEY_COUNT_W = 6;
   localparam int unsigned KEY_INDEX_W = 5;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned PROD_W      = FRAC_W + 1 + DATA_W + 1;
   localparam int unsigned REQ_DATA_W  = 168;
   localparam int unsigned RSP_DATA_W  = 104;
   localparam int unsigned CSR_ADDR_W  = 3;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_INTERP = 3'd0,
      STATUS_SINGLE = 3'd1,
      STATUS_CLAMP  = 3'd2,
      STATUS_EMPTY  = 3'd3,
      STATUS_WRITE  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_DIV,
      S_MUL,
      S_ADD,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      COMP_X = 2'd0,
      COMP_Y = 2'd1,
      COMP_Z = 2'd2
   } comp_type;

   localparam logic CSR_REG_KEY_COUNT = 1'b0;

endpackage

// ----- hdl/kvl_ram.sv -----
module kvl_ram #(
   parameter int unsigned WIDTH = 128,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- hdl/keyframe_vector_lerp_top.sv -----
// Keyframe track sampler: linear interpolation of a 3-component value.
// req channel: tuser = kind (0 writes a key, 1 queries a time). tdata carries
//   key_index, key_time, key_x, key_y, key_z and query_time.
// rsp channel: one transaction per request; tuser = status, tdata carries
//   out_x, out_y, out_z and segment.
// csr port: register key_count at byte address 0; write it only while idle.
// A key write goes from acceptance straight to the output state. A query reads
//   the key table through one registered RAM port, with a read state and a
//   check state per key visited, so the search visits up to key_count keys; a
//   hit inside the table then adds a restoring division for the 16-bit factor
//   and work on the one shared multiplier (one multiply and one add per
//   component), then the output state. One item is in work at a time.
// req_tready is high only while the sequencer is idle. The result sits in an
//   output register, so a stalled receiver does not hold up the next request;
//   the sequencer waits only if a second result is ready before the first is
//   taken.
// Reset clears the sequencer, the output valid and key_count. The key table
//   is not cleared; only written entries may be queried.
module keyframe_vector_lerp_top #(
   parameter int unsigned MAX_KEYS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [4:0] key_index, [36:5] key_time, [68:37] key_x, [100:69] key_y,
   // [132:101] key_z, [164:133] query_time, [167:165] zero
   input  logic [kvl_pkg::REQ_DATA_W-1:0]        req_tdata,
   // [0] kind
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] out_x, [63:32] out_y, [95:64] out_z, [100:96] segment, [103:101] zero
   output logic [kvl_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [2:0] status
   output logic [2:0]                            rsp_tuser,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [kvl_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int unsigned AW = $clog2(MAX_KEYS);
   localparam int unsigned DW = kvl_pkg::DATA_W;
   localparam int unsigned FW = kvl_pkg::FRAC_W;

   // request fields
   logic [kvl_pkg::KEY_INDEX_W-1:0] req_key_index;
   logic [DW-1:0]                   req_key_time, req_key_x, req_key_y, req_key_z;
   logic [DW-1:0]                   req_query_time;
   logic                            req_accept;

   assign req_key_index  = req_tdata[4:0];
   assign req_key_time   = req_tdata[36:5];
   assign req_key_x      = req_tdata[68:37];
   assign req_key_y      = req_tdata[100:69];
   assign req_key_z      = req_tdata[132:101];
   assign req_query_time = req_tdata[164:133];
   assign req_accept     = req_tvalid && req_tready;

   // configuration
   logic [kvl_pkg::KEY_COUNT_W-1:0] key_count_ff;
   logic [kvl_pkg::KEY_COUNT_W-1:0] num_keys;
   logic                            csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == kvl_pkg::CSR_REG_KEY_COUNT);
   assign csr_prdata = (csr_paddr[2] == kvl_pkg::CSR_REG_KEY_COUNT) ?
                       {{(32 - kvl_pkg::KEY_COUNT_W){1'b0}}, key_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else if (csr_write) begin
         key_count_ff <= csr_pwdata[kvl_pkg::KEY_COUNT_W-1:0];
      end
   end

   assign num_keys = (32'(key_count_ff) > MAX_KEYS) ?
                     kvl_pkg::KEY_COUNT_W'(MAX_KEYS) : key_count_ff;

   // key table
   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [kvl_pkg::ROW_W-1:0]  ram_wr_data;
   logic [kvl_pkg::ROW_W-1:0]  row;

   // sequencer and datapath registers
   kvl_pkg::state_type  state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       seg_ff, seg_in;
   logic [DW-1:0]       qtime_ff, qtime_in;
   logic [kvl_pkg::ROW_W-1:0] start_ff, start_in;
   logic [kvl_pkg::ROW_W-1:0] end_ff, end_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [FW-1:0]       quo_ff, quo_in;
   logic [3:0]          cnt_ff, cnt_in;
   kvl_pkg::comp_type   comp_ff, comp_in;
   logic signed [kvl_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [DW-1:0]       res_x_ff, res_x_in, res_y_ff, res_y_in, res_z_ff, res_z_in;
   logic [2:0]          res_status_ff, res_status_in;
   logic [4:0]          res_seg_ff, res_seg_in;
   logic [kvl_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0]          rsp_user_ff, rsp_user_in;

   // comparisons and arithmetic shared by the sequencer
   logic          is_first, is_last, time_below, out_free;
   logic [DW-1:0] den;
   logic [DW:0]   rem_shift;
   logic          sub_ok;
   logic [DW-1:0] comp_start, comp_end;
   logic signed [DW:0] comp_delta;

   assign is_first   = (idx_ff == '0);
   assign is_last    = (32'(idx_ff) == 32'(num_keys) - 32'd1);
   assign time_below = (qtime_ff < row[DW-1:0]);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign den       = end_ff[DW-1:0] - start_ff[DW-1:0];
   assign rem_shift = {rem_ff, 1'b0};
   assign sub_ok    = (rem_shift >= {1'b0, den});

   always_comb begin
      case (comp_ff)
         kvl_pkg::COMP_X: begin
            comp_start = start_ff[2*DW-1:DW];
            comp_end   = end_ff[2*DW-1:DW];
         end
         kvl_pkg::COMP_Y: begin
            comp_start = start_ff[3*DW-1:2*DW];
            comp_end   = end_ff[3*DW-1:2*DW];
         end
         default: begin
            comp_start = start_ff[4*DW-1:3*DW];
            comp_end   = end_ff[4*DW-1:3*DW];
         end
      endcase
   end

   assign comp_delta = $signed({comp_end[DW-1], comp_end}) -
                       $signed({comp_start[DW-1], comp_start});

   assign req_tready  = (state_ff == kvl_pkg::S_IDLE);
   assign ram_wr_en   = req_accept && (req_tuser == kvl_pkg::KIND_WRITE) &&
                        (32'(req_key_index) < MAX_KEYS);
   assign ram_wr_addr = AW'(req_key_index);
   assign ram_wr_data = {req_key_z, req_key_y, req_key_x, req_key_time};

   kvl_ram #(
      .WIDTH (kvl_pkg::ROW_W),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kvl_pkg::S_IDLE: begin
            if (req_accept) begin
               if (req_tuser == kvl_pkg::KIND_WRITE || num_keys == '0) begin
                  state_in = kvl_pkg::S_OUT;
               end else begin
                  state_in = kvl_pkg::S_READ;
               end
            end
         end
         kvl_pkg::S_READ: begin
            state_in = kvl_pkg::S_CHECK;
         end
         kvl_pkg::S_CHECK: begin
            if (is_first) begin
               if (num_keys == kvl_pkg::KEY_COUNT_W'(1) || time_below) begin
                  state_in = kvl_pkg::S_OUT;
               end else begin
                  state_in = kvl_pkg::S_READ;
               end
            end else if (time_below) begin
               state_in = kvl_pkg::S_DIV;
            end else if (is_last) begin
               state_in = kvl_pkg::S_OUT;
            end else begin
               state_in = kvl_pkg::S_READ;
            end
         end
         kvl_pkg::S_DIV: begin
            if (cnt_ff == 4'(FW - 1)) begin
               state_in = kvl_pkg::S_MUL;
            end
         end
         kvl_pkg::S_MUL: begin
            state_in = kvl_pkg::S_ADD;
         end
         kvl_pkg::S_ADD: begin
            if (comp_ff == kvl_pkg::COMP_Z) begin
               state_in = kvl_pkg::S_OUT;
            end else begin
               state_in = kvl_pkg::S_MUL;
            end
         end
         kvl_pkg::S_OUT: begin
            if (out_free) begin
               state_in = kvl_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kvl_pkg::S_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      idx_in        = idx_ff;
      seg_in        = seg_ff;
      qtime_in      = qtime_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      comp_in       = comp_ff;
      prod_in       = prod_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_z_in      = res_z_ff;
      res_status_in = res_status_ff;
      res_seg_in    = res_seg_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         kvl_pkg::S_IDLE: begin
            if (req_accept) begin
               qtime_in      = req_query_time;
               idx_in        = '0;
               res_x_in      = '0;
               res_y_in      = '0;
               res_z_in      = '0;
               res_seg_in    = '0;
               res_status_in = kvl_pkg::STATUS_EMPTY;
               if (req_tuser == kvl_pkg::KIND_WRITE) begin
                  res_status_in = kvl_pkg::STATUS_WRITE;
                  res_seg_in    = req_key_index;
               end
            end
         end
         kvl_pkg::S_CHECK: begin
            res_x_in = row[2*DW-1:DW];
            res_y_in = row[3*DW-1:2*DW];
            res_z_in = row[4*DW-1:3*DW];
            if (is_first) begin
               res_seg_in = '0;
               if (num_keys == kvl_pkg::KEY_COUNT_W'(1)) begin
                  res_status_in = kvl_pkg::STATUS_SINGLE;
               end else if (time_below) begin
                  res_status_in = kvl_pkg::STATUS_CLAMP;
               end else begin
                  start_in = row;
                  idx_in   = idx_ff + AW'(1);
               end
            end else if (time_below) begin
               // hit: segment [idx-1, idx], remainder starts at t - t_start
               seg_in = idx_ff - AW'(1);
               end_in = row;
               rem_in = qtime_ff - start_ff[DW-1:0];
               quo_in = '0;
               cnt_in = '0;
            end else if (is_last) begin
               res_seg_in    = 5'(idx_ff - AW'(1));
               res_status_in = (qtime_ff == row[DW-1:0]) ? kvl_pkg::STATUS_INTERP :
                                                           kvl_pkg::STATUS_CLAMP;
            end else begin
               start_in = row;
               idx_in   = idx_ff + AW'(1);
            end
         end
         kvl_pkg::S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (sub_ok) begin
               rem_in = DW'(rem_shift - {1'b0, den});
               quo_in = {quo_ff[FW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[DW-1:0];
               quo_in = {quo_ff[FW-2:0], 1'b0};
            end
            cnt_in  = cnt_ff + 4'd1;
            comp_in = kvl_pkg::COMP_X;
         end
         kvl_pkg::S_MUL: begin
            prod_in = kvl_pkg::PROD_W'($signed({1'b0, quo_ff})) *
                      kvl_pkg::PROD_W'(comp_delta);
         end
         kvl_pkg::S_ADD: begin
            // floor(prod / 65536) added to the start value
            case (comp_ff)
               kvl_pkg::COMP_X: res_x_in = comp_start + prod_ff[FW+DW-1:FW];
               kvl_pkg::COMP_Y: res_y_in = comp_start + prod_ff[FW+DW-1:FW];
               default:         res_z_in = comp_start + prod_ff[FW+DW-1:FW];
            endcase
            case (comp_ff)
               kvl_pkg::COMP_X: comp_in = kvl_pkg::COMP_Y;
               default:         comp_in = kvl_pkg::COMP_Z;
            endcase
            res_seg_in    = 5'(seg_ff);
            res_status_in = kvl_pkg::STATUS_INTERP;
         end
         kvl_pkg::S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, res_seg_ff, res_z_ff, res_y_ff, res_x_ff};
               rsp_user_in  = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         comp_ff      <= kvl_pkg::COMP_X;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff        <= seg_in;
      qtime_ff      <= qtime_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      prod_ff       <= prod_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_z_ff      <= res_z_in;
      res_status_ff <= res_status_in;
      res_seg_ff    <= res_seg_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned KEY_SLOTS  = 32;
   localparam int unsigned CYCLE_CAP  = 500_000;
   localparam int unsigned HOLD_SPAN  = 500;
   localparam int unsigned RANDOM_MIN = 400;

   typedef struct packed {
      kvl_pkg::kind_type kind;
      logic [4:0]        key_index;
      logic [31:0]       key_time;
      logic [31:0]       key_x;
      logic [31:0]       key_y;
      logic [31:0]       key_z;
      logic [31:0]       query_time;
   } track_request_type;

   typedef struct packed {
      logic [31:0]         x;
      logic [31:0]         y;
      logic [31:0]         z;
      kvl_pkg::status_type status;
      logic [4:0]          segment;
   } sample_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [kvl_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [kvl_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]                     rsp_tuser;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [kvl_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]                    csr_pwdata = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   keyframe_vector_lerp_top #(.MAX_KEYS(KEY_SLOTS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // predicted track contents and register copy
   logic [31:0] track_time [KEY_SLOTS];
   logic [31:0] track_x    [KEY_SLOTS];
   logic [31:0] track_y    [KEY_SLOTS];
   logic [31:0] track_z    [KEY_SLOTS];
   logic [5:0]  track_count = '0;

   // key times as the stimulus generator last wrote them
   logic [31:0] planned_time [KEY_SLOTS];

   track_request_type pending_requests [$];
   sample_type        expected_samples [$];
   track_request_type offered;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        hold_arm = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned items_planned = 0;
   int unsigned track_sizes = 0;
   int unsigned status_seen [8];

   function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input logic [15:0] frac);
      longint s;
      longint d;
      longint p;
      s = longint'(signed'(a));
      d = longint'(signed'(b)) - s;
      p = longint'(frac) * d;
      // arithmetic shift gives the floor for negative products
      return 32'(s + (p >>> 16));
   endfunction

   function automatic sample_type sample_track(input track_request_type it);
      sample_type  r;
      int unsigned n;
      int unsigned seg;
      bit          hit;
      logic [47:0] num;
      logic [31:0] den;
      logic [15:0] frac;
      r = '0;
      if (it.kind == kvl_pkg::KIND_WRITE) begin
         track_time[it.key_index] = it.key_time;
         track_x[it.key_index]    = it.key_x;
         track_y[it.key_index]    = it.key_y;
         track_z[it.key_index]    = it.key_z;
         r.status  = kvl_pkg::STATUS_WRITE;
         r.segment = it.key_index;
         return r;
      end
      n = (track_count > KEY_SLOTS) ? KEY_SLOTS : track_count;
      if (n == 0) begin
         r.status = kvl_pkg::STATUS_EMPTY;
         return r;
      end
      if (n == 1 || it.query_time < track_time[0]) begin
         r.x      = track_x[0];
         r.y      = track_y[0];
         r.z      = track_z[0];
         r.status = (n == 1) ? kvl_pkg::STATUS_SINGLE : kvl_pkg::STATUS_CLAMP;
         return r;
      end
      seg = n - 2;
      hit = 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
         if (!hit && it.query_time < track_time[i+1]) begin
            seg = i;
            hit = 1'b1;
         end
      end
      r.segment = seg[4:0];
      if (!hit) begin
         r.x = track_x[n-1];
         r.y = track_y[n-1];
         r.z = track_z[n-1];
         if (it.query_time == track_time[n-1]) begin
            r.status = kvl_pkg::STATUS_INTERP;
         end else begin
            r.status = kvl_pkg::STATUS_CLAMP;
         end
         return r;
      end
      num  = {it.query_time - track_time[seg], 16'h0000};
      den  = track_time[seg+1] - track_time[seg];
      frac = 16'(num / den);
      r.x      = blend(track_x[seg], track_x[seg+1], frac);
      r.y      = blend(track_y[seg], track_y[seg+1], frac);
      r.z      = blend(track_z[seg], track_z[seg+1], frac);
      r.status = kvl_pkg::STATUS_INTERP;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_samples = {expected_samples, sample_track(offered)};
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               offered = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= offered.kind;
               req_tdata  <= {3'b000, offered.query_time, offered.key_z, offered.key_y,
                              offered.key_x, offered.key_time, offered.key_index};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, taken once when armed
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_arm && !hold_taken) begin
         hold_left  <= HOLD_SPAN;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      sample_type got;
      sample_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x       = rsp_tdata[31:0];
         got.y       = rsp_tdata[63:32];
         got.z       = rsp_tdata[95:64];
         got.segment = rsp_tdata[100:96];
         got.status  = kvl_pkg::status_type'(rsp_tuser);
         status_seen[rsp_tuser]++;
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected sample: x=%h y=%h z=%h status=%0d segment=%0d",
                        got.x, got.y, got.z, got.status, got.segment);
            end
         end else begin
            want = expected_samples.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.status !== want.status || got.segment !== want.segment) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("sample mismatch: expected x=%h y=%h z=%h status=%0d segment=%0d",
                           want.x, want.y, want.z, want.status, want.segment);
                  $display("                 got      x=%h y=%h z=%h status=%0d segment=%0d",
                           got.x, got.y, got.z, got.status, got.segment);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5, 0))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_write(input logic [4:0] idx, input logic [31:0] t,
                             input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      track_request_type it;
      it.kind       = kvl_pkg::KIND_WRITE;
      it.key_index  = idx;
      it.key_time   = t;
      it.key_x      = x;
      it.key_y      = y;
      it.key_z      = z;
      it.query_time = $urandom;
      planned_time[idx] = t;
      pending_requests = {pending_requests, it};
      items_planned++;
   endtask

   task automatic push_query(input logic [31:0] t);
      track_request_type it;
      it.kind       = kvl_pkg::KIND_QUERY;
      it.key_index  = 5'($urandom);
      it.key_time   = $urandom;
      it.key_x      = $urandom;
      it.key_y      = $urandom;
      it.key_z      = $urandom;
      it.query_time = t;
      pending_requests = {pending_requests, it};
      items_planned++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write_key_count(input logic [5:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {kvl_pkg::CSR_REG_KEY_COUNT, 2'b00};
      csr_pwdata  <= {26'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      track_count = value;
   endtask

   task automatic begin_phase(input logic [5:0] count);
      wait_idle();
      csr_write_key_count(count);
      track_sizes++;
      @(negedge clock);
   endtask

   task automatic random_phase(input logic [5:0] count);
      int unsigned eff;
      int unsigned queries;
      int unsigned seg;
      logic [31:0] span_cap;
      logic [31:0] cursor;
      logic [31:0] t;
      begin_phase(count);
      eff = (count > KEY_SLOTS) ? KEY_SLOTS : count;
      // lay down an ascending track, small spans half the time
      span_cap = 32'hFFFF_FFFF / (eff + 1);
      if ($urandom_range(1, 0) == 0 && span_cap > 32'h0004_0000) span_cap = 32'h0004_0000;
      cursor = $urandom_range(span_cap, 0);
      for (int i = 0; i < eff; i++) begin
         push_write(5'(i), cursor, pick_word(), pick_word(), pick_word());
         cursor = cursor + $urandom_range(span_cap, 1);
      end
      queries = $urandom_range(20, 6);
      for (int q = 0; q < queries; q++) begin
         if ($urandom_range(7, 0) == 0) begin
            push_write(5'($urandom), pick_word(), pick_word(), pick_word(), pick_word());
         end else begin
            t = $urandom;
            if (eff >= 2) begin
               case ($urandom_range(9, 0))
                  0: t = $urandom;
                  1: t = planned_time[$urandom_range(eff - 1, 0)];
                  2: if (planned_time[0] != 0) t = $urandom_range(planned_time[0] - 1, 0);
                  3: if (planned_time[eff-1] != 32'hFFFF_FFFF)
                        t = $urandom_range(32'hFFFF_FFFF, planned_time[eff-1] + 1);
                  default: begin
                     seg = $urandom_range(eff - 2, 0);
                     if (planned_time[seg+1] > planned_time[seg])
                        t = $urandom_range(planned_time[seg+1] - 1, planned_time[seg]);
                  end
               endcase
            end
            push_query(t);
         end
      end
   endtask

   initial begin : stimulus
      int unsigned phase_no;
      int unsigned directed_items;
      logic [5:0]  count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 26;
      recv_idle_pct = 75;
      @(negedge clock);

      // empty track straight out of reset, plus writes at both ends of the table
      push_query(32'h0000_0000);
      push_query(32'hFFFF_FFFF);
      push_write(5'd31, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      push_write(5'd0, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      track_sizes++;

      begin_phase(6'd1);
      push_query(32'h0000_0005);

      // full-scale swings, factor from zero up to just under one
      begin_phase(6'd2);
      push_write(5'd0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
      push_write(5'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
      push_query(32'h0000_0000);
      push_query(32'h0001_0000);
      push_query(32'h8000_0000);
      push_query(32'hFFFF_FFFE);
      push_query(32'hFFFF_FFFF);

      // third key earlier than the second: track no longer ascending
      begin_phase(6'd3);
      push_write(5'd2, 32'h0002_0000, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000);
      push_query(32'h0001_8000);
      push_query(32'hFFFF_FFFF);

      begin_phase(6'd4);
      for (int i = 0; i < 4; i++) begin
         push_write(5'(i), 32'((i + 1) << 16), 32'(i * 32'h0001_8000),
                    32'h0010_0000 - 32'(i * 32'h0000_4001), 32'hFFFF_0000 + 32'(i));
      end
      push_query(32'h0004_0000);
      push_query(32'h0005_0000);
      push_query(32'h0002_8000);
      push_query(32'h0003_0000);
      directed_items = items_planned;

      phase_no = 0;
      while (items_planned < directed_items + RANDOM_MIN) begin
         if (items_planned < directed_items + RANDOM_MIN / 3) begin
            send_idle_pct = 26;
            recv_idle_pct = 75;
         end else if (items_planned < directed_items + 2 * RANDOM_MIN / 3) begin
            send_idle_pct = 75;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            // receiver stalls while the sender keeps offering
            hold_arm = 1'b1;
         end
         case (phase_no)
            0: count = 6'd32;
            1: count = 6'd63;
            default: begin
               case ($urandom_range(11, 0))
                  0:       count = 6'd0;
                  1:       count = 6'd1;
                  2:       count = 6'd32;
                  3:       count = 6'($urandom_range(63, 33));
                  4, 5:    count = 6'd2;
                  default: count = 6'($urandom_range(32, 2));
               endcase
            end
         endcase
         random_phase(count);
         phase_no++;
      end

      wait_idle();
      repeat (100) @(posedge clock);
      $display("Covered %0d key writes and %0d queries over %0d track settings",
               status_seen[kvl_pkg::STATUS_WRITE],
               items_planned - status_seen[kvl_pkg::STATUS_WRITE], track_sizes);
      $display("Query outcomes: %0d interpolated, %0d clamped, %0d single key, %0d empty",
               status_seen[kvl_pkg::STATUS_INTERP], status_seen[kvl_pkg::STATUS_CLAMP],
               status_seen[kvl_pkg::STATUS_SINGLE], status_seen[kvl_pkg::STATUS_EMPTY]);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
